>>> sv/kwx_pkg.sv
// ----------------------------------------------------------------------------
// kwx_pkg
// Types and constants shared by the keyword-triggered word extractor.
// ----------------------------------------------------------------------------
package kwx_pkg;

  // trigger text limits
  localparam int              TRIGGER_MAX_BYTES = 8;
  localparam logic [3:0]      TRIG_MAX_LEN      = 4'(TRIGGER_MAX_BYTES);

  // saturation of the extracted length
  localparam int              MAX_TARGET_LENGTH = 255;
  localparam int              TARGET_LIMIT_INT  =
    (MAX_TARGET_LENGTH < 255) ? MAX_TARGET_LENGTH : 255;
  localparam logic [7:0]      TARGET_LIMIT      = 8'(TARGET_LIMIT_INT);

  // characters
  localparam logic [7:0]      CH_NUL   = 8'd0;
  localparam logic [7:0]      CH_TAB   = 8'd9;
  localparam logic [7:0]      CH_LF    = 8'd10;
  localparam logic [7:0]      CH_FF    = 8'd12;
  localparam logic [7:0]      CH_SPACE = 8'd32;

  localparam logic signed [8:0] WORD_REST_OF_LINE = -9'sd1;

  // register indexes (byte address / 8)
  localparam logic [1:0]      REG_TRIG_BYTES  = 2'd0;
  localparam logic [1:0]      REG_TRIG_LENGTH = 2'd1;
  localparam logic [1:0]      REG_WORD_INDEX  = 2'd2;

  typedef enum logic [1:0] {
    PH_MATCH   = 2'd0,
    PH_COUNT   = 2'd1,
    PH_EXTRACT = 2'd2,
    PH_IDLE    = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] match_pos;
    logic [7:0] words_seen;
    logic [7:0] prev_byte;
    logic [7:0] extract_cnt;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       is_final;
    logic [7:0] length;
  } result_t;

endpackage

>>> sv/kwx_core.sv
// ----------------------------------------------------------------------------
// kwx_core
// Per-byte next-state and result logic: trigger match, word count, extraction.
// ----------------------------------------------------------------------------
module kwx_core (
  input  logic [7:0]          text_byte_i,
  input  kwx_pkg::state_t     st_i,
  input  logic [63:0]         trigger_bytes_i,
  input  logic [3:0]          trigger_length_i,
  input  logic signed [8:0]   word_index_i,
  output kwx_pkg::state_t     st_o,
  output kwx_pkg::result_t    res_o
);
  import kwx_pkg::*;

  logic [3:0] len;
  logic       blank_b;
  logic       blank_prev;
  logic       rest_of_line;
  logic [7:0] trig_cur;
  logic [7:0] trig_first;

  assign len          = (trigger_length_i > TRIG_MAX_LEN) ? TRIG_MAX_LEN : trigger_length_i;
  assign blank_b      = (text_byte_i == CH_SPACE) || (text_byte_i == CH_TAB) ||
                        (text_byte_i == CH_LF);
  assign blank_prev   = (st_i.prev_byte == CH_SPACE) || (st_i.prev_byte == CH_TAB) ||
                        (st_i.prev_byte == CH_LF);
  assign rest_of_line = (word_index_i == WORD_REST_OF_LINE);
  assign trig_cur     = trigger_bytes_i[{st_i.match_pos[2:0], 3'b000} +: 8];
  assign trig_first   = trigger_bytes_i[7:0];

  always_comb begin
    logic       do_count;
    logic       do_extract;
    logic [3:0] pos_nxt;
    logic [7:0] words_base;
    logic [7:0] words_new;
    logic       delim;

    st_o       = st_i;
    res_o      = '0;
    do_count   = 1'b0;
    do_extract = 1'b0;
    pos_nxt    = st_i.match_pos;
    words_base = st_i.words_seen;
    words_new  = st_i.words_seen;
    delim      = 1'b0;

    if (text_byte_i == CH_NUL) begin
      // end of string: report current length unless already finished
      res_o.valid    = (st_i.phase != PH_IDLE);
      res_o.is_final = 1'b1;
      res_o.length   = st_i.extract_cnt;
      st_o.phase       = PH_MATCH;
      st_o.match_pos   = '0;
      st_o.words_seen  = '0;
      st_o.prev_byte   = '0;
      st_o.extract_cnt = '0;
    end else begin
      st_o.prev_byte = text_byte_i;
      case (st_i.phase)
        PH_MATCH: begin
          if (st_i.match_pos < len) begin
            if (text_byte_i == trig_cur) begin
              pos_nxt = st_i.match_pos + 4'd1;
            end else begin
              // retry the breaking byte against the first trigger byte
              pos_nxt = (text_byte_i == trig_first) ? 4'd1 : 4'd0;
            end
            st_o.match_pos = pos_nxt;
            if (pos_nxt >= len) begin
              st_o.phase      = PH_COUNT;
              st_o.words_seen = '0;
            end
          end else begin
            // trigger already complete (empty or shortened): count this byte
            do_count   = 1'b1;
            words_base = '0;
          end
        end
        PH_COUNT: begin
          do_count = 1'b1;
        end
        PH_EXTRACT: begin
          do_extract = 1'b1;
        end
        default: begin
        end
      endcase

      if (do_count) begin
        words_new = words_base;
        if (blank_prev && !blank_b && (words_base != 8'hFF)) begin
          words_new = words_base + 8'd1;
        end
        st_o.words_seen = words_new;
        st_o.phase      = PH_COUNT;
        if ($signed({1'b0, words_new}) >= word_index_i) begin
          do_extract = 1'b1;
        end
      end

      if (do_extract) begin
        delim = rest_of_line ? ((text_byte_i == CH_LF) || (text_byte_i == CH_FF)) : blank_b;
        res_o.valid = 1'b1;
        if (delim) begin
          st_o.phase     = PH_IDLE;
          res_o.is_final = 1'b1;
          res_o.length   = st_i.extract_cnt;
        end else begin
          st_o.phase = PH_EXTRACT;
          if (st_i.extract_cnt < TARGET_LIMIT) begin
            st_o.extract_cnt = st_i.extract_cnt + 8'd1;
          end
          res_o.out_byte = text_byte_i;
          res_o.length   = st_o.extract_cnt;
        end
      end
    end
  end

endmodule

>>> sv/keyword_triggered_word_extractor.sv
// datapath: an item is registered on input, then its result (if any) is registered
//   on output
// throughput: one item per cycle; the input waits only while its result is held by a
//   stalled full output register; compares and an 8-bit counter step per byte
// reset: asynchronous, active low; clears the search state and the handshake,
//   and sets the trigger to one zero byte and the word index to zero
// ----------------------------------------------------------------------------
// keyword_triggered_word_extractor
// Finds a configured trigger in a byte stream and emits the selected word after it.
// ----------------------------------------------------------------------------
module keyword_triggered_word_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_final_o,
  output logic [7:0]  target_length_o
);
  import kwx_pkg::*;

  logic [63:0]       trig_bytes_q;
  logic [3:0]        trig_len_q;
  logic signed [8:0] word_index_q;
  logic              cfg_wr;

  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_go;
  logic              in_accept;

  state_t            st_q, st_d;
  result_t           core_res;

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_final_q;
  logic [7:0]        out_len_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_bytes_q <= '0;
      trig_len_q   <= 4'd1;
      word_index_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_TRIG_BYTES:  trig_bytes_q <= pwdata;
        REG_TRIG_LENGTH: trig_len_q   <= pwdata[3:0];
        REG_WORD_INDEX:  word_index_q <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_TRIG_BYTES:  prdata = trig_bytes_q;
      REG_TRIG_LENGTH: prdata = {60'd0, trig_len_q};
      REG_WORD_INDEX:  prdata = {55'd0, word_index_q};
      default:         prdata = '0;
    endcase
  end

  // input register stage; it only waits when its result has no free slot
  assign s1_go      = s1_valid_q && (!core_res.valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || s1_go) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= text_byte_i;
    end
  end

  kwx_core u_core (
    .text_byte_i      (s1_byte_q),
    .st_i             (st_q),
    .trigger_bytes_i  (trig_bytes_q),
    .trigger_length_i (trig_len_q),
    .word_index_i     (word_index_q),
    .st_o             (st_d),
    .res_o            (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= PH_MATCH;
      st_q.match_pos   <= '0;
      st_q.words_seen  <= '0;
      st_q.prev_byte   <= '0;
      st_q.extract_cnt <= '0;
    end else if (s1_go) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && core_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && core_res.valid) begin
      out_byte_q  <= core_res.out_byte;
      out_final_q <= core_res.is_final;
      out_len_q   <= core_res.length;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign is_final_o      = out_final_q;
  assign target_length_o = out_len_q;

  // a pending result with a stalled full output slot must hold the input
  a_hold_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && core_res.valid && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("result would overwrite a stalled output item");

  a_final_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_final_o |-> out_byte_o == CH_NUL)
    else $error("final item carries a nonzero byte");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && st_q.phase == PH_IDLE && s1_byte_q != CH_NUL |-> !core_res.valid)
    else $error("result produced while idle");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_final_o |-> target_length_o != 8'd0)
    else $error("extracted byte with zero length");

  a_match_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.match_pos <= TRIG_MAX_LEN)
    else $error("match position beyond trigger size");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives text strings into the word extractor under changing trigger and
// word settings, predicts every extracted byte and final length in step with
// the accepted items, and compares each result as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  import kwx_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic [7:0] len;
  } extract_res_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        is_final_o;
  logic [7:0]  target_length_o;

  keyword_triggered_word_extractor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .is_final_o      (is_final_o),
    .target_length_o (target_length_o)
  );

  always #5 clk_i = ~clk_i;

  // register copies seen by the extraction predictor
  logic [63:0]       trig_bytes_q = '0;
  logic [3:0]        trig_len_q   = 4'd1;
  logic signed [8:0] word_idx_q   = '0;

  // predicted scan state
  phase_e     scan_phase = PH_MATCH;
  logic [3:0] scan_match = '0;
  logic [7:0] scan_words = '0;
  logic [7:0] scan_prev  = '0;
  logic [7:0] scan_count = '0;

  logic [7:0]   byte_feed_q[$];
  extract_res_t expected_q[$];
  extract_res_t exp_res;
  int           stim_count     = 0;
  int           mismatch_count = 0;
  int           burst_left     = 0;
  int           gap_left       = 0;
  int           stall_left     = 0;
  int           stall_mode     = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF;
  endfunction

  function automatic logic [7:0] trig_char(input logic [3:0] k);
    return trig_bytes_q[8*k[2:0] +: 8];
  endfunction

  task automatic push_expect(input logic [7:0] ch, input logic fin, input logic [7:0] len);
    extract_res_t r;
    r.ch  = ch;
    r.fin = fin;
    r.len = len;
    expected_q.push_back(r);
  endtask

  task automatic restart_scan();
    scan_phase = PH_MATCH;
    scan_match = '0;
    scan_words = '0;
    scan_prev  = '0;
    scan_count = '0;
  endtask

  // advance the predicted scan by one accepted item
  task automatic extract_step(input logic [7:0] b);
    logic [3:0] eff_len;
    bit         rest_mode;
    eff_len   = (trig_len_q > TRIG_MAX_LEN) ? TRIG_MAX_LEN : trig_len_q;
    rest_mode = (word_idx_q == WORD_REST_OF_LINE);
    if (b == CH_NUL) begin
      if (scan_phase != PH_IDLE) push_expect(CH_NUL, 1'b1, scan_count);
      restart_scan();
      return;
    end
    if (scan_phase == PH_IDLE) begin
      scan_prev = b;
      return;
    end
    if (scan_phase == PH_MATCH) begin
      if (scan_match < eff_len) begin
        // a byte that breaks a partial match may still start a new one
        if (b == trig_char(scan_match)) scan_match++;
        else scan_match = (b == trig_char(4'd0)) ? 4'd1 : 4'd0;
        if (scan_match >= eff_len) begin
          scan_phase = PH_COUNT;
          scan_words = '0;
        end
        scan_prev = b;
        return;
      end
      // length dropped under the match position: trigger counts as found
      scan_phase = PH_COUNT;
      scan_words = '0;
    end
    if (scan_phase == PH_COUNT) begin
      if (is_blank(scan_prev) && !is_blank(b) && scan_words != 8'd255) scan_words++;
      if (int'(scan_words) >= int'(word_idx_q)) begin
        scan_phase = PH_EXTRACT;
      end else begin
        scan_prev = b;
        return;
      end
    end
    scan_prev = b;
    if (rest_mode ? (b == CH_LF || b == CH_FF) : is_blank(b)) begin
      scan_phase = PH_IDLE;
      push_expect(CH_NUL, 1'b1, scan_count);
      return;
    end
    if (scan_count < TARGET_LIMIT) scan_count++;
    push_expect(b, 1'b0, scan_count);
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      text_byte_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) extract_step(text_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_feed_q.size() != 0) begin
          in_valid_i  <= 1'b1;
          text_byte_i <= byte_feed_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results and stalls in changing modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %0d final %0b length %0d",
                                    out_byte_o, is_final_o, target_length_o));
        end else begin
          exp_res = expected_q.pop_front();
          if (out_byte_o !== exp_res.ch)
            report_mismatch($sformatf("out_byte %0d, expected %0d", out_byte_o, exp_res.ch));
          if (is_final_o !== exp_res.fin)
            report_mismatch($sformatf("is_final %0b, expected %0b", is_final_o, exp_res.fin));
          if (target_length_o !== exp_res.len)
            report_mismatch($sformatf("target_length %0d, expected %0d",
                                      target_length_o, exp_res.len));
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall_i <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] c);
    byte_feed_q.push_back(c);
    stim_count++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(97, 122));
    do c = 8'($urandom_range(1, 255)); while (is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TRIG_BYTES:  trig_bytes_q = val;
      REG_TRIG_LENGTH: trig_len_q   = val[3:0];
      REG_WORD_INDEX:  word_idx_q   = val[8:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // block is quiet: nothing queued, nothing in flight, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_feed_q.size() != 0 || in_valid_i || expected_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_config();
    logic [63:0]       tb;
    logic [3:0]        tl;
    logic signed [8:0] wi;
    int                i;
    int                r;
    // small alphabet so partial matches overlap often
    for (i = 0; i < 8; i++) begin
      r = $urandom_range(0, 3);
      if (r < 2) tb[8*i +: 8] = 8'($urandom_range(97, 99));
      else if (r == 2) tb[8*i +: 8] = 8'($urandom_range(97, 122));
      else tb[8*i +: 8] = 8'($urandom_range(1, 255));
    end
    r = $urandom_range(0, 19);
    if (r < 14) tl = 4'($urandom_range(1, 4));
    else if (r < 17) tl = 4'($urandom_range(5, 8));
    else if (r < 19) tl = 4'($urandom_range(9, 15));
    else tl = 4'd0;
    r = $urandom_range(0, 19);
    if (r < 8) wi = 9'($urandom_range(0, 3));
    else if (r < 13) wi = WORD_REST_OF_LINE;
    else if (r < 16) wi = 9'($urandom_range(4, 10));
    else if (r < 18) wi = 9'(-int'($urandom_range(2, 256)));
    else wi = 9'($urandom_range(11, 255));
    write_reg(REG_TRIG_BYTES, tb);
    write_reg(REG_TRIG_LENGTH, {60'd0, tl});
    write_reg(REG_WORD_INDEX, {55'd0, wi});
  endtask

  // mostly trigger followed by words, with noise and broken trigger attempts
  task automatic gen_string();
    int eff;
    int i;
    int k;
    int n_words;
    eff = (trig_len_q > TRIG_MAX_LEN) ? TRIGGER_MAX_BYTES : int'(trig_len_q);
    repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)));
    if (eff > 1 && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, eff - 1);
      for (i = 0; i < k; i++) push_byte(trig_char(4'(i)));
      push_byte(word_char());
    end
    if ($urandom_range(0, 9) != 0) begin
      for (i = 0; i < eff; i++) push_byte(trig_char(4'(i)));
    end
    n_words = $urandom_range(0, 5);
    for (i = 0; i < n_words; i++) begin
      if (i > 0 || $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 2)) push_byte(blank_char());
      end
      repeat ($urandom_range(1, 6)) push_byte(word_char());
    end
    case ($urandom_range(0, 7))
      0: push_byte(CH_LF);
      1: push_byte(CH_FF);
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0) push_byte(CH_NUL);
  endtask

  initial begin
    int random_start;
    int phase_end;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: end of string while searching
    push_byte(CH_NUL);
    push_byte(8'hFF);
    push_byte(CH_NUL);
    wait_idle();

    // broken partial match, then second word cut by end of string
    write_reg(REG_TRIG_BYTES, 64'h0079_656b);
    write_reg(REG_TRIG_LENGTH, 64'd3);
    write_reg(REG_WORD_INDEX, 64'd1);
    push_text("kkey a");
    push_byte(CH_NUL);
    wait_idle();

    // rest of line up to form feed, then byte 0 while idle
    write_reg(REG_WORD_INDEX, {55'd0, WORD_REST_OF_LINE});
    push_text("key");
    push_byte(CH_TAB);
    push_text("b");
    push_byte(CH_FF);
    push_byte(CH_NUL);
    wait_idle();

    // trigger length lowered under a partial match
    push_text("ke");
    wait_idle();
    write_reg(REG_TRIG_LENGTH, 64'd1);
    push_text("q");
    push_byte(CH_LF);
    push_byte(CH_NUL);
    wait_idle();

    // empty trigger with the most negative word index
    write_reg(REG_TRIG_LENGTH, 64'd0);
    write_reg(REG_WORD_INDEX, {55'd0, 9'h100});
    push_text("a b");
    push_byte(CH_NUL);
    wait_idle();

    random_start = stim_count;

    // all-ones trigger, length above the maximum, word long enough to saturate
    write_reg(REG_TRIG_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_TRIG_LENGTH, 64'd15);
    write_reg(REG_WORD_INDEX, 64'd0);
    repeat (8) push_byte(8'hFF);
    repeat (270) push_byte(word_char());
    push_byte(CH_NUL);
    wait_idle();

    // last word index: word count saturates
    write_reg(REG_TRIG_BYTES, 64'h6b);
    write_reg(REG_TRIG_LENGTH, 64'd1);
    write_reg(REG_WORD_INDEX, 64'd255);
    push_text("k");
    repeat (256) push_text(" x");
    push_byte(CH_NUL);
    wait_idle();

    while (stim_count - random_start < 1350) begin
      random_config();
      phase_end = stim_count + $urandom_range(40, 120);
      while (stim_count < phase_end) gen_string();
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
